/* rtl/scaled_glyph_renderer_core_defines.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the scaled glyph renderer
// Shared concurrent assertion forms used at the end of the top level.
// ----------------------------------------------------------------------------
`ifndef SCALED_GLYPH_RENDERER_CORE_DEFINES_SVH
`define SCALED_GLYPH_RENDERER_CORE_DEFINES_SVH

// A condition that must hold at every clock edge outside reset.
`define SGR_ASSERT_ALWAYS(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// A consequence that must hold in the same cycle as its cause.
`define SGR_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// A consequence that must hold in the cycle after its cause.
`define SGR_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* rtl/sgr_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Scaled glyph renderer package
// Operation codes, frame store request type and the built-in 5x7 font.
// ----------------------------------------------------------------------------
package sgr_pkg;

   localparam int STORE_DEPTH = 1024;
   localparam int ADDR_W      = 10;
   localparam int GLYPH_COLS  = 5;
   localparam int GLYPH_ROWS  = 7;

   localparam logic [1:0] OP_CLEAR = 2'd0;
   localparam logic [1:0] OP_DRAW  = 2'd1;
   localparam logic [1:0] OP_READ  = 2'd2;
   localparam logic [1:0] OP_NONE  = 2'd3;

   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_NINE  = 8'h39;
   localparam logic [7:0] CHAR_COLON = 8'h3A;
   localparam logic [7:0] CHAR_DOT   = 8'h2E;
   localparam logic [7:0] CHAR_DASH  = 8'h2D;
   localparam logic [7:0] CHAR_SPACE = 8'h20;
   localparam logic [7:0] CHAR_LOW_C = 8'h63;
   localparam logic [7:0] CHAR_UP_C  = 8'h43;

   localparam logic [3:0] GLYPH_COLON = 4'd10;
   localparam logic [3:0] GLYPH_DOT   = 4'd11;
   localparam logic [3:0] GLYPH_DASH  = 4'd12;
   localparam logic [3:0] GLYPH_SPACE = 4'd13;
   localparam logic [3:0] GLYPH_C     = 4'd14;

   typedef struct packed {
      logic              rd_en;
      logic              wr_en;
      logic [ADDR_W-1:0] addr;
      logic [7:0]        wr_data;
   } store_req_type;

   typedef struct packed {
      logic       valid;
      logic [3:0] index;
   } glyph_sel_type;

   function automatic glyph_sel_type glyph_lookup(input logic [7:0] code);
      glyph_sel_type sel;
      sel.valid = 1'b1;
      sel.index = 4'd0;
      if (code >= CHAR_ZERO && code <= CHAR_NINE) begin
         sel.index = 4'(code - CHAR_ZERO);
      end else if (code == CHAR_COLON) begin
         sel.index = GLYPH_COLON;
      end else if (code == CHAR_DOT) begin
         sel.index = GLYPH_DOT;
      end else if (code == CHAR_DASH) begin
         sel.index = GLYPH_DASH;
      end else if (code == CHAR_SPACE) begin
         sel.index = GLYPH_SPACE;
      end else if (code == CHAR_LOW_C || code == CHAR_UP_C) begin
         sel.index = GLYPH_C;
      end else begin
         sel.valid = 1'b0;
      end
      return sel;
   endfunction

   // Five font columns, leftmost column in the lowest byte; bit n is row n.
   function automatic logic [39:0] glyph_row(input logic [3:0] index);
      logic [39:0] bits;
      case (index)
         4'd0:    bits = {8'h3E, 8'h45, 8'h49, 8'h51, 8'h3E};
         4'd1:    bits = {8'h00, 8'h40, 8'h7F, 8'h42, 8'h00};
         4'd2:    bits = {8'h46, 8'h49, 8'h51, 8'h61, 8'h42};
         4'd3:    bits = {8'h31, 8'h4B, 8'h45, 8'h41, 8'h21};
         4'd4:    bits = {8'h10, 8'h7F, 8'h12, 8'h14, 8'h18};
         4'd5:    bits = {8'h39, 8'h45, 8'h45, 8'h45, 8'h27};
         4'd6:    bits = {8'h30, 8'h49, 8'h49, 8'h4A, 8'h3C};
         4'd7:    bits = {8'h03, 8'h05, 8'h09, 8'h71, 8'h01};
         4'd8:    bits = {8'h36, 8'h49, 8'h49, 8'h49, 8'h36};
         4'd9:    bits = {8'h1E, 8'h29, 8'h49, 8'h49, 8'h06};
         4'd10:   bits = {8'h00, 8'h00, 8'h36, 8'h36, 8'h00};
         4'd11:   bits = {8'h60, 8'h00, 8'h00, 8'h00, 8'h00};
         4'd12:   bits = {8'h08, 8'h08, 8'h08, 8'h08, 8'h08};
         4'd14:   bits = {8'h04, 8'h22, 8'h22, 8'h22, 8'h1C};
         default: bits = 40'd0;
      endcase
      return bits;
   endfunction

endpackage

`default_nettype wire

/* rtl/scaled_glyph_renderer_core.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Scaled glyph renderer core
// Draws 5x7 font characters at an integer scale into a paged monochrome
// frame store, clears the store and reads single store bytes back.
// ----------------------------------------------------------------------------
//
//   Channel  Direction  Handshake                 Carries
//   req_*    in         req_tvalid / req_tready   one request: op, character, position
//   rsp_*    out        rsp_tvalid / rsp_tready   one result per request
//
// Sequence: a rendered glyph is drawn font column by font column. Each font
// column builds its row mask from its seven rows with the shared shifter,
// then every pixel column walks the pages and does a read-modify-write of
// the single-port frame store for each page that holds pixels.
// Reset: after reset the store is cleared in one pass over every address,
// during which no request is taken. Stalls: a finished result waits in an
// output register, so the next request is accepted while rsp_tready is low.
// ----------------------------------------------------------------------------
`include "scaled_glyph_renderer_core_defines.svh"

module scaled_glyph_renderer_core
   import sgr_pkg::*;
#(
   parameter int PANEL_WIDTH  = 128,
   parameter int PANEL_HEIGHT = 64,
   parameter int MAX_SCALE    = 8
) (
   input  wire logic        clock,
   input  wire logic        reset,
   // Request channel.
   input  wire logic        req_tvalid,
   output logic             req_tready,
   // tdata from bit 0: char_code[7:0], first[8], start_x[16:9],
   // start_y[24:17], scale[28:25], read_address[38:29], zero fill[39].
   input  wire logic [39:0] req_tdata,
   // tuser from bit 0: op[1:0].
   input  wire logic [1:0]  req_tuser,
   // Result channel.
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   // tdata from bit 0: read_data[7:0], glyph_drawn[8], string_full[9],
   // cursor_x[17:10], zero fill[23:18].
   output logic [23:0]      rsp_tdata
);

   // Number of pages that cover the panel, and the row mask that spans them.
   localparam int PAGES  = (PANEL_HEIGHT + 7) / 8;
   localparam int MASK_W = PAGES * 8;
   localparam int PAGE_W = (PAGES > 1) ? $clog2(PAGES) : 1;
   localparam logic [MASK_W-1:0] ROW_LIMIT =
      MASK_W'((65'd1 << PANEL_HEIGHT) - 65'd1);

   // Sequencer states.
   localparam logic [2:0] S_CLEAR   = 3'd0;
   localparam logic [2:0] S_IDLE    = 3'd1;
   localparam logic [2:0] S_CHECK   = 3'd2;
   localparam logic [2:0] S_COLMASK = 3'd3;
   localparam logic [2:0] S_PAGE    = 3'd4;
   localparam logic [2:0] S_WRITE   = 3'd5;
   localparam logic [2:0] S_READ    = 3'd6;
   localparam logic [2:0] S_EMIT    = 3'd7;

   // Request fields.
   logic [1:0]  req_op;
   logic [7:0]  req_char_code;
   logic        req_first;
   logic [7:0]  req_start_x;
   logic [7:0]  req_start_y;
   logic [3:0]  req_scale;
   logic [9:0]  req_read_address;

   assign req_op           = req_tuser[1:0];
   assign req_char_code    = req_tdata[7:0];
   assign req_first        = req_tdata[8];
   assign req_start_x      = req_tdata[16:9];
   assign req_start_y      = req_tdata[24:17];
   assign req_scale        = req_tdata[28:25];
   assign req_read_address = req_tdata[38:29];

   // Control state.
   logic [2:0]        state_ff, state_in;
   logic              boot_ff, boot_in;
   logic [ADDR_W-1:0] clr_addr_ff, clr_addr_in;
   logic [7:0]        cursor_ff, cursor_in;
   logic [7:0]        line_top_ff, line_top_in;
   logic [3:0]        scale_ff, scale_in;
   logic              full_ff, full_in;
   logic              rsp_valid_ff, rsp_valid_in;

   // Working registers of the current request.
   glyph_sel_type     gsel_ff, gsel_in;
   logic [7:0]        px_ff, px_in;
   logic [2:0]        col_ff, col_in;
   logic [2:0]        row_ff, row_in;
   logic [2:0]        sx_ff, sx_in;
   logic [6:0]        pos_ff, pos_in;
   logic [MASK_W-1:0] vmask_ff, vmask_in;
   logic [PAGE_W-1:0] page_ff, page_in;
   logic [ADDR_W-1:0] page_base_ff, page_base_in;
   logic [ADDR_W-1:0] addr_ff, addr_in;
   logic [7:0]        rdata_ff, rdata_in;
   logic              drawn_ff, drawn_in;
   logic [23:0]       rsp_data_ff, rsp_data_in;

   // Frame store port.
   store_req_type     store_req;
   logic [7:0]        store_rd_data;

   sgr_frame_store u_store (
      .clock      (clock),
      .req        (store_req),
      .rd_data_ff (store_rd_data)
   );

   // Character cell arithmetic for the latched scale.
   logic [5:0]  cell_w;
   logic [3:0]  gap_w;
   logic        over_edge;
   logic        render_ok;
   logic        accept;

   assign cell_w    = 6'({scale_ff, 2'b00}) + 6'(scale_ff);
   assign gap_w     = (scale_ff >= 4'd4) ? 4'd1 : scale_ff;
   assign over_edge = (9'(cursor_ff) + 9'(cell_w)) > 9'(PANEL_WIDTH);
   assign render_ok = gsel_ff.valid && (scale_ff != 4'd0)
                      && (9'(cursor_ff) < 9'(PANEL_WIDTH))
                      && (9'(line_top_ff) < 9'(PANEL_HEIGHT));
   assign accept    = req_tvalid && req_tready;

   // Shared shifter: a run of scale ones placed at the current row position.
   logic [39:0]       glyph_bits;
   logic [7:0]        col_bits;
   logic [MASK_W-1:0] run_ones;
   logic [MASK_W-1:0] run_shifted;
   logic [7:0]        page_byte;
   logic              last_page;

   assign glyph_bits  = glyph_row(gsel_ff.index);
   assign col_bits    = glyph_bits[{col_ff, 3'b000} +: 8];
   assign run_ones    = (MASK_W'(1) << scale_ff) - MASK_W'(1);
   assign run_shifted = (run_ones << pos_ff) & ROW_LIMIT;
   assign page_byte   = vmask_ff[{page_ff, 3'b000} +: 8];
   assign last_page   = (page_ff == PAGE_W'(PAGES - 1));

   assign req_tready  = (state_ff == S_IDLE);
   assign rsp_tvalid  = rsp_valid_ff;
   assign rsp_tdata   = rsp_data_ff;

   always_comb begin
      logic advance;

      state_in     = state_ff;
      boot_in      = boot_ff;
      clr_addr_in  = clr_addr_ff;
      cursor_in    = cursor_ff;
      line_top_in  = line_top_ff;
      scale_in     = scale_ff;
      full_in      = full_ff;
      gsel_in      = gsel_ff;
      px_in        = px_ff;
      col_in       = col_ff;
      row_in       = row_ff;
      sx_in        = sx_ff;
      pos_in       = pos_ff;
      vmask_in     = vmask_ff;
      page_in      = page_ff;
      page_base_in = page_base_ff;
      addr_in      = addr_ff;
      rdata_in     = rdata_ff;
      drawn_in     = drawn_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      advance      = 1'b0;

      store_req         = '0;
      store_req.addr    = addr_ff;
      store_req.wr_data = 8'h00;

      unique case (state_ff)
         S_CLEAR: begin
            store_req.wr_en = 1'b1;
            store_req.addr  = clr_addr_ff;
            clr_addr_in     = clr_addr_ff + ADDR_W'(1);
            if (clr_addr_ff == ADDR_W'(STORE_DEPTH - 1)) begin
               boot_in  = 1'b0;
               state_in = boot_ff ? S_IDLE : S_EMIT;
            end
         end
         S_IDLE: begin
            if (accept) begin
               rdata_in = 8'h00;
               drawn_in = 1'b0;
               unique case (req_op)
                  OP_CLEAR: begin
                     clr_addr_in = '0;
                     state_in    = S_CLEAR;
                  end
                  OP_DRAW: begin
                     gsel_in = glyph_lookup(req_char_code);
                     if (req_first) begin
                        cursor_in   = req_start_x;
                        line_top_in = req_start_y;
                        scale_in    = (req_scale > 4'(MAX_SCALE)) ? 4'(MAX_SCALE)
                                                                   : req_scale;
                        full_in     = 1'b0;
                     end
                     state_in = S_CHECK;
                  end
                  OP_READ: begin
                     store_req.rd_en = 1'b1;
                     store_req.addr  = req_read_address;
                     state_in        = S_READ;
                  end
                  OP_NONE: begin
                     state_in = S_EMIT;
                  end
                  default: begin
                     state_in = S_EMIT;
                  end
               endcase
            end
         end
         S_CHECK: begin
            if (full_ff) begin
               state_in = S_EMIT;
            end else if (over_edge) begin
               full_in  = 1'b1;
               state_in = S_EMIT;
            end else begin
               cursor_in = cursor_ff + 8'(cell_w) + 8'(gap_w);
               drawn_in  = render_ok;
               px_in     = cursor_ff;
               col_in    = '0;
               row_in    = '0;
               sx_in     = '0;
               pos_in    = line_top_ff[6:0];
               vmask_in  = '0;
               state_in  = render_ok ? S_COLMASK : S_EMIT;
            end
         end
         S_COLMASK: begin
            if (col_bits[row_ff]) begin
               vmask_in = vmask_ff | run_shifted;
            end
            pos_in = pos_ff + 7'(scale_ff);
            row_in = row_ff + 3'd1;
            if (row_ff == 3'(GLYPH_ROWS - 1)) begin
               page_in      = '0;
               page_base_in = '0;
               state_in     = S_PAGE;
            end
         end
         S_PAGE: begin
            if ((px_ff < 8'(PANEL_WIDTH)) && (page_byte != 8'h00)) begin
               store_req.rd_en = 1'b1;
               store_req.addr  = page_base_ff + ADDR_W'(px_ff);
               addr_in         = page_base_ff + ADDR_W'(px_ff);
               state_in        = S_WRITE;
            end else begin
               advance = 1'b1;
            end
         end
         S_WRITE: begin
            store_req.wr_en   = 1'b1;
            store_req.addr    = addr_ff;
            store_req.wr_data = store_rd_data | page_byte;
            advance           = 1'b1;
         end
         S_READ: begin
            rdata_in = store_rd_data;
            state_in = S_EMIT;
         end
         S_EMIT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {6'b000000, cursor_ff, full_ff, drawn_ff, rdata_ff};
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      // Step to the next page, pixel column or font column of the glyph.
      if (advance) begin
         if (last_page) begin
            page_in      = '0;
            page_base_in = '0;
            px_in        = px_ff + 8'd1;
            if (sx_ff == 3'(scale_ff - 4'd1)) begin
               sx_in = '0;
               if (col_ff == 3'(GLYPH_COLS - 1)) begin
                  state_in = S_EMIT;
               end else begin
                  col_in   = col_ff + 3'd1;
                  row_in   = '0;
                  pos_in   = line_top_ff[6:0];
                  vmask_in = '0;
                  state_in = S_COLMASK;
               end
            end else begin
               sx_in    = sx_ff + 3'd1;
               state_in = S_PAGE;
            end
         end else begin
            page_in      = page_ff + PAGE_W'(1);
            page_base_in = page_base_ff + ADDR_W'(PANEL_WIDTH);
            state_in     = S_PAGE;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         boot_ff      <= 1'b1;
         clr_addr_ff  <= '0;
         cursor_ff    <= '0;
         line_top_ff  <= '0;
         scale_ff     <= '0;
         full_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         boot_ff      <= boot_in;
         clr_addr_ff  <= clr_addr_in;
         cursor_ff    <= cursor_in;
         line_top_ff  <= line_top_in;
         scale_ff     <= scale_in;
         full_ff      <= full_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      gsel_ff      <= gsel_in;
      px_ff        <= px_in;
      col_ff       <= col_in;
      row_ff       <= row_in;
      sx_ff        <= sx_in;
      pos_ff       <= pos_in;
      vmask_ff     <= vmask_in;
      page_ff      <= page_in;
      page_base_ff <= page_base_in;
      addr_ff      <= addr_in;
      rdata_ff     <= rdata_in;
      drawn_ff     <= drawn_in;
      rsp_data_ff  <= rsp_data_in;
   end

   // Conditions watched by the assertions below.
   logic write_step;
   logic addr_in_panel;
   logic page_lit;
   logic cursor_hold;

   assign write_step    = (state_ff == S_WRITE);
   assign addr_in_panel = (11'(addr_ff) < 11'(PAGES * PANEL_WIDTH));
   assign page_lit      = (page_byte != 8'h00);
   assign cursor_hold   = !accept && (state_ff != S_CHECK);

   // A glyph write never lands outside the pages of the panel.
   `SGR_ASSERT_IMPLY(a_write_in_panel, clock, reset, write_step, addr_in_panel, "write off panel")

   // A read-modify-write is only spent on a page that holds pixels.
   `SGR_ASSERT_IMPLY(a_write_pixels, clock, reset, write_step, page_lit, "empty page mask")

   // The cursor moves only when a string starts or a character cell is placed.
   `SGR_ASSERT_NEXT(a_cursor_steady, clock, reset, cursor_hold, $stable(cursor_ff), "cursor moved")

endmodule

`default_nettype wire

/* rtl/sgr_frame_store.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Scaled glyph renderer frame store
// Single-port byte memory with a registered read, one access per cycle.
// ----------------------------------------------------------------------------
module sgr_frame_store
   import sgr_pkg::*;
(
   input  wire logic          clock,
   input  wire store_req_type req,
   output logic [7:0]         rd_data_ff
);

   logic [7:0] mem [STORE_DEPTH];

   always_ff @(posedge clock) begin
      if (req.wr_en) begin
         mem[req.addr] <= req.wr_data;
      end
      if (req.rd_en) begin
         rd_data_ff <= mem[req.addr];
      end
   end

endmodule

`default_nettype wire

/* verif/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Scaled glyph renderer core testbench
// Sends clear, draw, read and ignored requests to the renderer and keeps a
// shadow copy of the frame store, the cursor and the string settings. Every
// report the block returns is checked field by field against the shadow.
// ----------------------------------------------------------------------------
module tb;
   import sgr_pkg::*;

   localparam int PANEL_WIDTH  = 128;
   localparam int PANEL_HEIGHT = 64;
   localparam int MAX_SCALE    = 8;

   // Roughly the number of requests in the random part.
   localparam int RANDOM_REQUESTS = 1650;
   // Longest stretch with no handshake on either side before the run is
   // abandoned; several times the sum of a clear, a draw at full scale and
   // the receiver hold-off.
   localparam int QUIET_LIMIT  = 10000;
   // Every request yields a report, so little can still be in flight once
   // the last expected report is in.
   localparam int DRAIN_CYCLES = 100;
   localparam int HOLD_CYCLES  = 600;
   localparam int HOLD_AFTER   = 400;
   // Both sides stop idling while their counts lie in this window.
   localparam int CALM_FROM    = 800;
   localparam int CALM_UNTIL   = 1000;
   localparam int IDLE_PERCENT = 26;

   // Not in the font; used to show that the cursor still moves.
   localparam logic [7:0] CHAR_UP_A = 8'h41;

   typedef struct {
      logic [1:0] op;
      logic [7:0] char_code;
      logic       first;
      logic [7:0] start_x;
      logic [7:0] start_y;
      logic [3:0] scale;
      logic [9:0] read_address;
   } glyph_request_type;

   typedef struct {
      logic [7:0] read_data;
      logic       glyph_drawn;
      logic       string_full;
      logic [7:0] cursor_x;
   } glyph_report_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   // From bit 0: char_code[7:0], first[8], start_x[16:9], start_y[24:17],
   // scale[28:25], read_address[38:29], zero fill[39].
   logic [39:0] req_tdata = '0;
   // From bit 0: op[1:0].
   logic [1:0]  req_tuser = OP_NONE;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   // From bit 0: read_data[7:0], glyph_drawn[8], string_full[9],
   // cursor_x[17:10], zero fill[23:18].
   logic [23:0] rsp_tdata;

   scaled_glyph_renderer_core #(
      .PANEL_WIDTH  (PANEL_WIDTH),
      .PANEL_HEIGHT (PANEL_HEIGHT),
      .MAX_SCALE    (MAX_SCALE)
   ) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   // Shadow of the block's state, as it stands after every accepted request.
   logic [7:0]     shadow_frame [1024];
   logic [7:0]     shadow_cursor = '0;
   logic [7:0]     shadow_line_top = '0;
   logic [3:0]     shadow_scale = '0;
   logic           shadow_full = 1'b0;

   glyph_request_type queued_glyph_requests[$];
   glyph_report_type  awaited_glyph_reports[$];
   glyph_request_type offered_request;
   int             requests_offered = 0;
   int             requests_accepted = 0;
   int             reports_seen = 0;
   int             quiet_cycles = 0;
   int             failures = 0;

   // Font slot of a character, or -1 where the font has no glyph for it.
   function automatic int font_slot(input logic [7:0] code);
      if (code >= CHAR_ZERO && code <= CHAR_NINE) return int'(code) - int'(CHAR_ZERO);
      if (code == CHAR_COLON) return int'(GLYPH_COLON);
      if (code == CHAR_DOT) return int'(GLYPH_DOT);
      if (code == CHAR_DASH) return int'(GLYPH_DASH);
      if (code == CHAR_SPACE) return int'(GLYPH_SPACE);
      if (code == CHAR_LOW_C || code == CHAR_UP_C) return int'(GLYPH_C);
      return -1;
   endfunction

   // The five font columns of a glyph, leftmost column in the top byte.
   function automatic logic [39:0] font_columns(input int slot);
      case (slot)
         0:       return 40'h3E_51_49_45_3E;
         1:       return 40'h00_42_7F_40_00;
         2:       return 40'h42_61_51_49_46;
         3:       return 40'h21_41_45_4B_31;
         4:       return 40'h18_14_12_7F_10;
         5:       return 40'h27_45_45_45_39;
         6:       return 40'h3C_4A_49_49_30;
         7:       return 40'h01_71_09_05_03;
         8:       return 40'h36_49_49_49_36;
         9:       return 40'h06_49_49_29_1E;
         10:      return 40'h00_36_36_00_00;
         11:      return 40'h00_00_00_00_60;
         12:      return 40'h08_08_08_08_08;
         14:      return 40'h1C_22_22_22_04;
         default: return 40'h00_00_00_00_00;
      endcase
   endfunction

   // ORs a glyph into the shadow store, clipping at the panel edges. Returns
   // 1 when the glyph counts as drawn, even if every pixel was clipped.
   function automatic logic paint_glyph(input int x, input int y, input int slot,
                                        input int s);
      logic [39:0] columns;
      logic [7:0]  column_bits;
      int          px, py, byte_index;
      if (slot < 0 || s == 0 || x >= PANEL_WIDTH || y >= PANEL_HEIGHT) return 1'b0;
      columns = font_columns(slot);
      for (int col = 0; col < 5; col++) begin
         column_bits = columns[8 * (4 - col) +: 8];
         for (int row = 0; row < 7; row++) begin
            if (column_bits[row]) begin
               for (int sy = 0; sy < s; sy++) begin
                  for (int sx = 0; sx < s; sx++) begin
                     px = x + col * s + sx;
                     py = y + row * s + sy;
                     if (px < PANEL_WIDTH && py < PANEL_HEIGHT) begin
                        byte_index = (py / 8) * PANEL_WIDTH + px;
                        shadow_frame[byte_index][py % 8] = 1'b1;
                     end
                  end
               end
            end
         end
      end
      return 1'b1;
   endfunction

   // Applies one accepted request to the shadow state and returns the report
   // the block should give for it.
   function automatic glyph_report_type render_into_shadow(input glyph_request_type r);
      glyph_report_type rep;
      int            s, cell_width, gap;
      rep.read_data   = '0;
      rep.glyph_drawn = 1'b0;
      case (r.op)
         OP_CLEAR: begin
            foreach (shadow_frame[i]) shadow_frame[i] = '0;
         end
         OP_READ: begin
            rep.read_data = shadow_frame[r.read_address];
         end
         OP_DRAW: begin
            if (r.first) begin
               shadow_cursor   = r.start_x;
               shadow_line_top = r.start_y;
               shadow_scale    = (r.scale > MAX_SCALE) ? 4'(MAX_SCALE) : r.scale;
               shadow_full     = 1'b0;
            end
            if (!shadow_full) begin
               s          = int'(shadow_scale);
               cell_width = 5 * s;
               // The spacing stays at one pixel from scale four upwards.
               gap        = (s >= 4) ? 1 : s;
               if (int'(shadow_cursor) + cell_width > PANEL_WIDTH) begin
                  shadow_full = 1'b1;
               end else begin
                  rep.glyph_drawn = paint_glyph(int'(shadow_cursor), int'(shadow_line_top),
                                                font_slot(r.char_code), s);
                  shadow_cursor = 8'(int'(shadow_cursor) + cell_width + gap);
               end
            end
         end
         default: begin
         end
      endcase
      rep.string_full = shadow_full;
      rep.cursor_x    = shadow_cursor;
      return rep;
   endfunction

   // A request with every field random; callers overwrite what matters.
   function automatic glyph_request_type any_request();
      glyph_request_type r;
      r.op           = 2'($urandom_range(0, 3));
      r.char_code    = 8'($urandom_range(0, 255));
      r.first        = 1'($urandom_range(0, 1));
      r.start_x      = 8'($urandom_range(0, 255));
      r.start_y      = 8'($urandom_range(0, 255));
      r.scale        = 4'($urandom_range(0, 15));
      r.read_address = 10'($urandom_range(0, 1023));
      return r;
   endfunction

   function automatic logic [7:0] font_char();
      int pick;
      pick = $urandom_range(0, 15);
      case (pick)
         10:      return CHAR_COLON;
         11:      return CHAR_DOT;
         12:      return CHAR_DASH;
         13:      return CHAR_SPACE;
         14:      return CHAR_LOW_C;
         15:      return CHAR_UP_C;
         default: return 8'(int'(CHAR_ZERO) + pick);
      endcase
   endfunction

   task automatic queue_draw(input logic first, input logic [7:0] code,
                             input logic [7:0] x, input logic [7:0] y,
                             input logic [3:0] s);
      glyph_request_type r;
      r           = any_request();
      r.op        = OP_DRAW;
      r.first     = first;
      r.char_code = code;
      if (first) begin
         r.start_x = x;
         r.start_y = y;
         r.scale   = s;
      end
      queued_glyph_requests.push_back(r);
   endtask

   task automatic queue_read(input logic [9:0] address);
      glyph_request_type r;
      r              = any_request();
      r.op           = OP_READ;
      r.read_address = address;
      queued_glyph_requests.push_back(r);
   endtask

   task automatic queue_op(input logic [1:0] op);
      glyph_request_type r;
      r    = any_request();
      r.op = op;
      queued_glyph_requests.push_back(r);
   endtask

   task automatic compare_field(input string field, input logic [7:0] want,
                                input logic [7:0] got);
      if (got !== want) begin
         $display("%0t ns: %s expected %0h, actual %0h", $time, field, want, got);
         failures++;
      end
   endtask

   // Sender: a new request is put on the bus at the falling edge once the
   // previous one has been taken, unless this cycle is an idle one.
   always @(negedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || requests_accepted == requests_offered) begin
         if (queued_glyph_requests.size() > 0 &&
             ((requests_offered >= CALM_FROM && requests_offered < CALM_UNTIL) ||
              $urandom_range(0, 99) >= IDLE_PERCENT)) begin
            offered_request = queued_glyph_requests.pop_front();
            req_tdata  <= {1'b0, offered_request.read_address, offered_request.scale,
                           offered_request.start_y, offered_request.start_x,
                           offered_request.first, offered_request.char_code};
            req_tuser  <= offered_request.op;
            req_tvalid <= 1'b1;
            requests_offered++;
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // Receiver: stalls at random, and once holds off for a long stretch so
   // that the output register fills and the block has to refuse requests.
   int  hold_left = 0;
   logic hold_done = 1'b0;

   always @(negedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left  <= hold_left - 1;
         rsp_tready <= 1'b0;
      end else if (!hold_done && reports_seen >= HOLD_AFTER) begin
         hold_done  <= 1'b1;
         hold_left  <= HOLD_CYCLES;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= (reports_seen >= CALM_FROM && reports_seen < CALM_UNTIL) ||
                       ($urandom_range(0, 99) >= IDLE_PERCENT);
      end
   end

   // Monitor: predicts on every accepted request and checks every accepted
   // report against the oldest one still awaited.
   always @(posedge clock) begin : monitor
      glyph_report_type got, want;
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            awaited_glyph_reports.push_back(render_into_shadow(offered_request));
            requests_accepted++;
         end
         if (rsp_tvalid && rsp_tready) begin
            got.read_data   = rsp_tdata[7:0];
            got.glyph_drawn = rsp_tdata[8];
            got.string_full = rsp_tdata[9];
            got.cursor_x    = rsp_tdata[17:10];
            if (awaited_glyph_reports.size() == 0) begin
               $display("%0t ns: report expected none, actual %h", $time, rsp_tdata);
               failures++;
            end else begin
               want = awaited_glyph_reports.pop_front();
               compare_field("read_data", want.read_data, got.read_data);
               compare_field("glyph_drawn", 8'(want.glyph_drawn), 8'(got.glyph_drawn));
               compare_field("string_full", 8'(want.string_full), 8'(got.string_full));
               compare_field("cursor_x", want.cursor_x, got.cursor_x);
            end
            reports_seen++;
         end
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
            quiet_cycles = 0;
         end else begin
            quiet_cycles++;
         end
      end
   end

   initial begin : run_control
      int             random_count, pick, burst;
      logic [7:0]     x, y;
      logic [3:0]     s;
      glyph_request_type r;
      foreach (shadow_frame[i]) shadow_frame[i] = '0;
      random_count = 0;

      // Directed part. A plain string at the origin, then its bytes read back.
      queue_draw(1'b1, CHAR_ZERO, 8'd0, 8'd0, 4'd1);
      queue_read(10'd0);
      queue_read(10'd2);
      queue_draw(1'b0, CHAR_NINE, 8'd0, 8'd0, 4'd0);
      // Near the bottom right, so the lower rows are clipped.
      queue_draw(1'b1, CHAR_UP_C, 8'd100, 8'd60, 4'd2);
      queue_read(10'(7 * PANEL_WIDTH + 101));
      // A scale above the maximum saturates; an unknown character only
      // moves the cursor; the third cell fits; the fourth runs off the edge.
      queue_draw(1'b1, CHAR_ZERO + 8'd1, 8'd0, 8'd0, 4'd15);
      queue_draw(1'b0, CHAR_UP_A, 8'd0, 8'd0, 4'd0);
      queue_draw(1'b0, CHAR_COLON, 8'd0, 8'd0, 4'd0);
      queue_draw(1'b0, CHAR_DOT, 8'd0, 8'd0, 4'd0);
      // Once the string is full, further characters do nothing.
      queue_draw(1'b0, CHAR_DASH, 8'd0, 8'd0, 4'd0);
      queue_read(10'd96);
      // Starts past the right edge.
      queue_draw(1'b1, CHAR_SPACE, 8'd255, 8'd255, 4'd8);
      // Top row below the panel: the cursor moves but nothing is drawn.
      queue_draw(1'b1, CHAR_LOW_C, 8'd10, 8'd64, 4'd3);
      // Scale zero: nothing drawn, the cursor stays put.
      queue_draw(1'b1, CHAR_NINE, 8'd128, 8'd0, 4'd0);
      queue_draw(1'b1, CHAR_ZERO + 8'd5, 8'd123, 8'd57, 4'd1);
      queue_read(10'd1023);
      queue_op(OP_NONE);
      queue_draw(1'b1, CHAR_ZERO + 8'd7, 8'd0, 8'd8, 4'd4);
      queue_read(10'(PANEL_WIDTH + 4));
      // A clear keeps the cursor and the string settings.
      queue_op(OP_CLEAR);
      queue_read(10'(PANEL_WIDTH + 4));
      queue_draw(1'b0, CHAR_ZERO + 8'd3, 8'd0, 8'd0, 4'd0);
      queue_read(10'(2 * PANEL_WIDTH + 30));

      // Random part. Mostly whole strings followed by reads of the bytes
      // they touched, with some stray reads, clears and noise.
      while (random_count < RANDOM_REQUESTS) begin
         pick = $urandom_range(0, 99);
         if (pick < 70) begin
            x = ($urandom_range(0, 99) < 85) ? 8'($urandom_range(0, 127))
                                             : 8'($urandom_range(0, 255));
            y = ($urandom_range(0, 99) < 85) ? 8'($urandom_range(0, 63))
                                             : 8'($urandom_range(0, 255));
            pick = $urandom_range(0, 99);
            // Large scales are slow, so most strings stay small.
            if (pick < 55)      s = 4'($urandom_range(1, 2));
            else if (pick < 80) s = ($urandom_range(0, 1) == 1) ? 4'd3 : 4'd0;
            else if (pick < 95) s = 4'($urandom_range(4, MAX_SCALE));
            else                s = 4'($urandom_range(MAX_SCALE + 1, 15));
            burst = $urandom_range(1, 6);
            for (int k = 0; k < burst; k++) begin
               queue_draw(k == 0, ($urandom_range(0, 99) < 80) ? font_char()
                                                               : 8'($urandom_range(0, 255)),
                          x, y, s);
            end
            random_count += burst;
            burst = $urandom_range(1, 4);
            for (int k = 0; k < burst; k++) begin
               queue_read(10'((((y >> 3) + $urandom_range(0, 1)) % 8) * PANEL_WIDTH +
                              (int'(x) + $urandom_range(0, 40)) % PANEL_WIDTH));
            end
            random_count += burst;
         end else if (pick < 85) begin
            queue_read(10'($urandom_range(0, 1023)));
            random_count++;
         end else if (pick < 88) begin
            queue_op(OP_CLEAR);
            random_count++;
         end else if (pick < 90) begin
            queue_op(OP_NONE);
            random_count++;
         end else begin
            r = any_request();
            if (r.op == OP_NONE) r.op = OP_DRAW;
            queued_glyph_requests.push_back(r);
            random_count++;
         end
      end

      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      while (!(queued_glyph_requests.size() == 0 && requests_accepted == requests_offered &&
               awaited_glyph_reports.size() == 0) && quiet_cycles < QUIET_LIMIT) begin
         @(negedge clock);
      end
      if (quiet_cycles < QUIET_LIMIT) begin
         repeat (DRAIN_CYCLES) @(negedge clock);
      end

      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("Mismatches found");
      end else if (failures == 0 && awaited_glyph_reports.size() == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
